// ===== src/sps_pkg.sv =====
package sps_pkg;

  localparam int POS_W = 24;
  localparam int UB_W  = 23;
  localparam int SL_W  = 16;
  localparam int TH_W  = 10;
  localparam int TGT_W = 6;
  localparam int PAT_W = 4;
  localparam int IDX_W = 3;
  localparam int CFG_W = UB_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [TH_W-1:0] TH_RST = TH_W'(500);

  // full-step coil phases, bit3 A1, bit2 A2, bit1 B1, bit0 B2
  localparam logic [PAT_W-1:0] PAT_PH1 = 4'd6;
  localparam logic [PAT_W-1:0] PAT_PH2 = 4'd3;
  localparam logic [PAT_W-1:0] PAT_PH3 = 4'd9;
  localparam logic [PAT_W-1:0] PAT_PH4 = 4'd12;
  localparam logic [PAT_W-1:0] PAT_OFF = 4'd0;

  localparam logic [IDX_W-1:0] IDX_STOP_LAST = 3'd0;
  localparam logic [IDX_W-1:0] IDX_HOME_LAST = 3'd3;
  localparam logic [IDX_W-1:0] IDX_STEP_LAST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOTION_ENABLE = 2'd0,
    CFG_SWITCH_THRESHOLD = 2'd1,
    CFG_LOOP_LEN = 2'd2,
    CFG_UPPER_BOUND = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_HOME = 1'b1
  } req_t;

  typedef struct packed {
    logic              req_type;
    logic [TGT_W-1:0]  target_cm;
    logic [TH_W-1:0]   right_switch_level;
    logic [TH_W-1:0]   left_switch_level;
  } in_item_t;

  typedef struct packed {
    logic [PAT_W-1:0]        coil_pattern;
    logic signed [POS_W-1:0] position_q16;
    logic                    limit_hit;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic              active;
    logic              limit;
    logic              right;
    logic [IDX_W-1:0]  last_idx;
    logic signed [POS_W-1:0] pos;
  } burst_desc_t;

  typedef struct packed {
    logic             motion_enable;
    logic [TH_W-1:0]  switch_threshold;
    logic [SL_W-1:0]  loop_len;
    logic [UB_W-1:0]  upper_bound;
  } cfg_t;

  function automatic logic [PAT_W-1:0] seq_pattern(input logic right,
                                                   input logic [IDX_W-1:0] idx);
    logic [PAT_W-1:0] pat;
    unique case (idx)
      3'd0:    pat = right ? PAT_PH3 : PAT_PH1;
      3'd1:    pat = PAT_PH2;
      3'd2:    pat = right ? PAT_PH1 : PAT_PH3;
      3'd3:    pat = PAT_PH4;
      default: pat = PAT_OFF;
    endcase
    return pat;
  endfunction

endpackage

// ===== src/stepper_position_seeker.sv =====
// Full-step stepper position control. Each accepted request is either a control
// tick or a homing step. A tick with motion enabled rounds the Q(FRAC_BITS)
// position to whole cm and, if it differs from target_cm and no bound refuses
// the move, emits either one all-off stop pattern (limit_hit set) when a limit
// switch reads below switch_threshold, or the four coil phases of the chosen
// direction plus all-off, moving the position by one loop length (saturating).
// A homing step emits the left phases (or one stop pattern) and clears the
// position. Every result carries the position after the item; last marks the
// final result. An item that yields no result retires when it is decided, and
// the output register emits one coil pattern per cycle while out_stall allows.
// Input, burst descriptor and output are one register each, so the next request
// is decided while the previous burst finishes, and a request passes the input
// register and the descriptor before its first result reaches the output.
module stepper_position_seeker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [22:0]              cfg_wdata,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sps_pkg::in_item_t        in_data,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output sps_pkg::out_item_t       out_data
);
  import sps_pkg::*;

  // reset values of the fixed-point registers follow the fraction width
  localparam longint unsigned SL_RAW =
    (64'd706422018 * (64'd1 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
  localparam longint unsigned SL_MAX = (64'd1 << SL_W) - 64'd1;
  localparam logic [SL_W-1:0] SL_RST = SL_W'((SL_RAW > SL_MAX) ? SL_MAX : SL_RAW);
  localparam longint unsigned UB_RAW = 64'd38 << FRAC_BITS;
  localparam longint unsigned UB_MAX = (64'd1 << UB_W) - 64'd1;
  localparam logic [UB_W-1:0] UB_RST = UB_W'((UB_RAW > UB_MAX) ? UB_MAX : UB_RAW);

  cfg_t                    cfg_r;
  logic                    ivld_r;
  in_item_t                item_r;
  logic signed [POS_W-1:0] pos_r;
  burst_desc_t             desc;
  logic                    burst_free;
  logic                    dec_go;
  logic                    load;
  logic                    in_xfer;

  // configuration registers; the user must write them only while idle, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_enable    <= 1'b0;
      cfg_r.switch_threshold <= TH_RST;
      cfg_r.loop_len         <= SL_RST;
      cfg_r.upper_bound      <= UB_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MOTION_ENABLE:    cfg_r.motion_enable    <= cfg_wdata[0];
        CFG_SWITCH_THRESHOLD: cfg_r.switch_threshold <= cfg_wdata[TH_W-1:0];
        CFG_LOOP_LEN:         cfg_r.loop_len         <= cfg_wdata[SL_W-1:0];
        CFG_UPPER_BOUND:      cfg_r.upper_bound      <= cfg_wdata[UB_W-1:0];
        default: ;
      endcase
    end
  end

  // the held request is decided as soon as the pattern burst can take it;
  // requests with no result retire in that same cycle
  assign dec_go   = ivld_r && burst_free;
  assign load     = dec_go && desc.active;
  assign in_stall = ivld_r && !burst_free;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      if (in_xfer) begin
        ivld_r <= 1'b1;
      end else if (dec_go) begin
        ivld_r <= 1'b0;
      end
      // position moves when the request is decided, before its patterns go out
      if (dec_go) begin
        pos_r <= desc.pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
  end

  // direction, bounds, switches, rounding and the next position
  sps_decide #(
    .FRAC_BITS (FRAC_BITS)
  ) u_decide (
    .item (item_r),
    .cfg  (cfg_r),
    .pos  (pos_r),
    .desc (desc)
  );

  // steps through the coil sequence, one result transfer per cycle unless stalled
  sps_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .desc      (desc),
    .free      (burst_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/sps_decide.sv =====
module sps_decide #(
  parameter int FRAC_BITS = 16
) (
  input  sps_pkg::in_item_t        item,
  input  sps_pkg::cfg_t            cfg,
  input  logic signed [23:0]       pos,
  output sps_pkg::burst_desc_t     desc
);
  import sps_pkg::*;

  localparam int CMP_W = (TGT_W + FRAC_BITS >= POS_W) ? TGT_W + FRAC_BITS + 1 : POS_W + 1;
  localparam logic [POS_W:0] HALF = (POS_W+1)'(1) << (FRAC_BITS - 1);

  logic              pressed;
  logic              neg;
  logic [POS_W:0]    mag;
  logic [POS_W:0]    rnd;
  logic              at_target;
  logic signed [CMP_W-1:0] tgt_fix;
  logic signed [CMP_W-1:0] pos_ext;
  logic              right;
  logic              blocked;
  logic signed [POS_W:0] sum;
  logic signed [POS_W-1:0] pos_step;

  assign pressed = (item.right_switch_level < cfg.switch_threshold) ||
                   (item.left_switch_level < cfg.switch_threshold);

  // round half away from zero to whole cm
  assign neg = pos[POS_W-1];
  assign mag = neg ? -{pos[POS_W-1], pos} : {1'b0, pos};
  assign rnd = (mag + HALF) >> FRAC_BITS;
  assign at_target = neg ? ((rnd == '0) && (item.target_cm == '0))
                         : (rnd == (POS_W+1)'(item.target_cm));

  assign tgt_fix = $signed(CMP_W'(item.target_cm) << FRAC_BITS);
  assign pos_ext = CMP_W'(pos);
  assign right   = tgt_fix >= pos_ext;

  assign blocked = right ? (pos > $signed({1'b0, cfg.upper_bound})) : neg;

  assign sum = right ? ((POS_W+1)'(pos) + $signed({1'b0, (POS_W)'(cfg.loop_len)}))
                     : ((POS_W+1)'(pos) - $signed({1'b0, (POS_W)'(cfg.loop_len)}));

  always_comb begin
    if (sum[POS_W] != sum[POS_W-1]) begin
      pos_step = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_step = sum[POS_W-1:0];
    end
  end

  always_comb begin
    desc.active   = 1'b0;
    desc.limit    = 1'b0;
    desc.right    = 1'b0;
    desc.last_idx = IDX_STOP_LAST;
    desc.pos      = pos;
    if (item.req_type == REQ_HOME) begin
      desc.active   = 1'b1;
      desc.limit    = pressed;
      desc.last_idx = pressed ? IDX_STOP_LAST : IDX_HOME_LAST;
      desc.pos      = '0;
    end else if (cfg.motion_enable && !at_target && !blocked) begin
      desc.active = 1'b1;
      if (pressed) begin
        desc.limit = 1'b1;
      end else begin
        desc.right    = right;
        desc.last_idx = IDX_STEP_LAST;
        desc.pos      = pos_step;
      end
    end
  end

endmodule

// ===== src/sps_burst.sv =====
module sps_burst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sps_pkg::burst_desc_t desc,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sps_pkg::out_item_t   out_data
);
  import sps_pkg::*;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  burst_desc_t      desc_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             out_free;
  logic             emit;
  logic             fin;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = busy_r && out_free;
  assign fin      = emit && (idx_r == desc_r.last_idx);
  assign free     = !busy_r || fin;

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.coil_pattern = desc_r.limit ? PAT_OFF : seq_pattern(desc_r.right, idx_r);
      out_data_nxt.position_q16 = desc_r.pos;
      out_data_nxt.limit_hit    = desc_r.limit;
      out_data_nxt.last         = fin;
      idx_nxt                   = idx_r + 1'b1;
    end
    if (fin) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (load) begin
      desc_r <= desc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // burst index never runs past its last pattern
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= desc_r.last_idx))
    else $error("burst index beyond last pattern");

  // a limit stop is a single all-off result
  a_stop_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.limit_hit) |->
      (out_data_r.last && (out_data_r.coil_pattern == PAT_OFF)))
    else $error("limit stop is not a single off pattern");

  // the burst goes idle after its last result unless a new one is loaded
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && !load) |=> !busy_r)
    else $error("burst still busy after last result");

  // a new burst is only loaded when the previous one is finished
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !fin) |-> !load)
    else $error("burst overwritten while in progress");

endmodule
